### rtl/qmps_pkg.sv
// ----------------------------------------------------------------------------
// qmps_pkg
// Widths, scoring constants and shared types of the QR mask penalty scorer.
// ----------------------------------------------------------------------------
package qmps_pkg;

	localparam int SIDE_W   = 8;
	localparam int DARK_W   = 16;
	localparam int RUN_W    = 16;
	localparam int BLOCK_W  = 17;
	localparam int FINDER_W = 22;
	localparam int TOTAL_W  = 22;
	localparam int BAL_W    = 7;
	localparam int WIN_W    = 11;

	localparam logic [RUN_W-1:0]    RUN_MAX    = '1;
	localparam logic [BLOCK_W-1:0]  BLOCK_MAX  = '1;
	localparam logic [FINDER_W-1:0] FINDER_MAX = '1;
	localparam logic [TOTAL_W-1:0]  TOTAL_MAX  = '1;

	localparam logic [SIDE_W-1:0]  RUN_LEN_MAX = '1;
	localparam logic [SIDE_W-1:0]  RUN_MIN     = 8'd5;
	localparam logic [SIDE_W-1:0]  RUN_BIAS    = 8'd2;
	localparam logic [BLOCK_W:0]   BLOCK_PTS   = 18'd3;
	localparam logic [6:0]         FINDER_PTS  = 7'd40;
	localparam logic [SIDE_W-1:0]  WIN_START   = 8'd10;

	localparam logic [WIN_W-1:0] FINDER_LEAD  = 11'h5D0;
	localparam logic [WIN_W-1:0] FINDER_TRAIL = 11'h05D;

	// register word index, taken from paddr[2]
	localparam logic REG_MATRIX_SIZE = 1'b0;

	typedef struct packed {
		logic [SIDE_W-1:0] run_len;
		logic              colour;
		logic [WIN_W-1:0]  window;
	} col_entry_t;

	typedef struct packed {
		logic             done;
		logic [BAL_W-1:0] balance;
	} bal_res_t;

endpackage

### rtl/qr_mask_penalty_score_top.sv
// ----------------------------------------------------------------------------
// qr_mask_penalty_score_top
// Scores the four QR mask penalty rules over one symbol streamed in raster
// order; per-column run, colour and window state lives in a column memory.
// ----------------------------------------------------------------------------
// Throughput: one module item per cycle within a symbol; each item is read
// from the column memory on acceptance and written back in the cycle after.
// After the last item of a symbol is accepted, the result comes out of the
// balance multiply, prepare and 4 division steps; the next symbol's first
// item is taken once that result has been emitted.
// Reset: all control and scoring state clears at once, matrix_size is 21; the
// column memory needs no clearing since row 0 writes every entry it uses.
module qr_mask_penalty_score_top import qmps_pkg::*; #(
	parameter int MAX_SIZE = 256
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [2:0]          paddr,
	input  logic [31:0]         pwdata,
	output logic [31:0]         prdata,
	output logic                pready,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic                module_dark,
	output logic                out_valid,
	input  logic                out_stall,
	output logic [TOTAL_W-1:0]  total_score,
	output logic [RUN_W-1:0]    run_score,
	output logic [BLOCK_W-1:0]  block_score,
	output logic [FINDER_W-1:0] finder_score,
	output logic [BAL_W-1:0]    balance_score
);

	localparam int CW = (MAX_SIZE > 1) ? $clog2(MAX_SIZE) : 1;
	localparam logic [SIDE_W:0] MAX_N = (SIDE_W+1)'(MAX_SIZE);

	typedef enum logic [2:0] {
		ST_RUN  = 3'b001,
		ST_CALC = 3'b010,
		ST_OUT  = 3'b100
	} state_t;

	function automatic logic [SIDE_W-1:0] run_pen(input logic [SIDE_W-1:0] len);
		return (len >= RUN_MIN) ? len - RUN_BIAS : '0;
	endfunction

	state_t              state_q;
	logic [SIDE_W-1:0]   ms_q;
	logic [SIDE_W-1:0]   side;
	logic [SIDE_W-1:0]   row_q, col_q;
	logic                cfg_wr;
	logic                in_acc;
	logic                out_free;
	logic                last_col, last_row;

	// row state and scoring accumulators
	logic [SIDE_W-1:0]   row_len_q;
	logic                row_colour_q;
	logic [WIN_W-1:0]    row_win_q;
	logic                upleft_q;
	logic [DARK_W-1:0]   dark_q;
	logic [RUN_W-1:0]    run_q;
	logic [BLOCK_W-1:0]  block_q;
	logic [FINDER_W-1:0] finder_q;

	// stage 1: item under update, with its column entry
	logic                s1_valid_q;
	logic                b_s1;
	logic [SIDE_W-1:0]   col_s1;
	logic                first_col_s1, last_col_s1, first_row_s1, last_row_s1;
	logic                cge10_s1, rge10_s1;
	col_entry_t          rd_s1;
	logic                s1_last;

	col_entry_t          col_mem [MAX_SIZE];

	logic [SIDE_W-1:0]   row_len_new;
	logic                row_colour_new;
	logic [WIN_W-1:0]    row_win_new;
	logic [SIDE_W-1:0]   row_close;
	col_entry_t          col_new;
	logic [SIDE_W-1:0]   col_close;
	logic                block_hit, row_hit, col_hit;
	logic [6:0]          finder_add;
	logic [RUN_W:0]      run_sum;
	logic [BLOCK_W:0]    block_sum;
	logic [FINDER_W:0]   finder_sum;
	logic [TOTAL_W:0]    total_sum;
	logic [TOTAL_W-1:0]  total_sat;
	logic                bal_start;
	bal_res_t            bal_res;

	// configuration port
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_MATRIX_SIZE);

	always_comb begin
		prdata = '0;
		if (psel && paddr[2] == REG_MATRIX_SIZE) prdata = 32'(ms_q);
	end

	always_comb begin
		if (ms_q == '0) side = 8'd1;
		else if ({1'b0, ms_q} > MAX_N) side = MAX_N[SIDE_W-1:0];
		else side = ms_q;
	end

	assign s1_last  = s1_valid_q && last_col_s1 && last_row_s1;
	assign in_stall = (state_q != ST_RUN) || s1_last;
	assign in_acc   = in_valid && !in_stall;
	assign out_free = !out_valid || !out_stall;
	assign last_col = col_q == side - 8'd1;
	assign last_row = row_q == side - 8'd1;

	// update of one module against the row registers and its column entry
	always_comb begin
		row_close      = '0;
		row_len_new    = row_len_q;
		row_colour_new = row_colour_q;
		if (first_col_s1) begin
			row_len_new    = 8'd1;
			row_colour_new = b_s1;
			row_win_new    = {{(WIN_W-1){1'b0}}, b_s1};
		end else begin
			row_win_new = {row_win_q[WIN_W-2:0], b_s1};
			if (b_s1 == row_colour_q) begin
				if (row_len_q != RUN_LEN_MAX) row_len_new = row_len_q + 8'd1;
				if (last_col_s1) row_close = row_len_new;
			end else begin
				row_close      = row_len_q;
				row_len_new    = 8'd1;
				row_colour_new = b_s1;
			end
		end

		col_close = '0;
		col_new   = rd_s1;
		if (first_row_s1) begin
			col_new.run_len = 8'd1;
			col_new.colour  = b_s1;
			col_new.window  = {{(WIN_W-1){1'b0}}, b_s1};
		end else begin
			col_new.window = {rd_s1.window[WIN_W-2:0], b_s1};
			if (b_s1 == rd_s1.colour) begin
				if (rd_s1.run_len != RUN_LEN_MAX) col_new.run_len = rd_s1.run_len + 8'd1;
				if (last_row_s1) col_close = col_new.run_len;
			end else begin
				col_close       = rd_s1.run_len;
				col_new.run_len = 8'd1;
				col_new.colour  = b_s1;
			end
		end

		block_hit = !first_row_s1 && !first_col_s1 && (b_s1 == row_colour_q)
			&& (b_s1 == rd_s1.colour) && (b_s1 == upleft_q);
		row_hit = cge10_s1 && (row_win_new == FINDER_LEAD || row_win_new == FINDER_TRAIL);
		col_hit = rge10_s1 && (col_new.window == FINDER_LEAD
			|| col_new.window == FINDER_TRAIL);
		case ({row_hit, col_hit})
			2'b11:         finder_add = FINDER_PTS << 1;
			2'b10, 2'b01:  finder_add = FINDER_PTS;
			default:       finder_add = '0;
		endcase

		run_sum    = {1'b0, run_q} + (RUN_W+1)'(run_pen(row_close))
			+ (RUN_W+1)'(run_pen(col_close));
		block_sum  = {1'b0, block_q} + (block_hit ? BLOCK_PTS : '0);
		finder_sum = {1'b0, finder_q} + (FINDER_W+1)'(finder_add);

		total_sum = (TOTAL_W+1)'(run_q) + (TOTAL_W+1)'(block_q)
			+ (TOTAL_W+1)'(finder_q) + (TOTAL_W+1)'(bal_res.balance);
		total_sat = total_sum[TOTAL_W] ? TOTAL_MAX : total_sum[TOTAL_W-1:0];
	end

	// column memory: read on acceptance, write back from stage 1. A column is read again no
	// sooner than two items later, or after the end-of-symbol stall at side one, so the write always lands first.
	always_ff @(posedge clk) begin
		if (in_acc) rd_s1 <= col_mem[col_q[CW-1:0]];
		if (s1_valid_q) col_mem[col_s1[CW-1:0]] <= col_new;
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			b_s1         <= module_dark;
			col_s1       <= col_q;
			first_col_s1 <= col_q == '0;
			first_row_s1 <= row_q == '0;
			last_col_s1  <= last_col;
			last_row_s1  <= last_row;
			cge10_s1     <= col_q >= WIN_START;
			rge10_s1     <= row_q >= WIN_START;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ms_q       <= 8'd21;
			row_q      <= '0;
			col_q      <= '0;
			s1_valid_q <= 1'b0;
		end else begin
			s1_valid_q <= in_acc;
			if (cfg_wr) begin
				ms_q  <= pwdata[SIDE_W-1:0];
				row_q <= '0;
				col_q <= '0;
			end else if (in_acc) begin
				if (!last_col) begin
					col_q <= col_q + 8'd1;
				end else begin
					col_q <= '0;
					row_q <= last_row ? '0 : row_q + 8'd1;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_len_q    <= '0;
			row_colour_q <= 1'b0;
			row_win_q    <= '0;
			upleft_q     <= 1'b0;
			dark_q       <= '0;
			run_q        <= '0;
			block_q      <= '0;
			finder_q     <= '0;
		end else if (cfg_wr || (state_q == ST_OUT && out_free)) begin
			// restart the scan
			row_len_q    <= '0;
			row_colour_q <= 1'b0;
			row_win_q    <= '0;
			dark_q       <= '0;
			run_q        <= '0;
			block_q      <= '0;
			finder_q     <= '0;
		end else if (s1_valid_q) begin
			row_len_q    <= row_len_new;
			row_colour_q <= row_colour_new;
			row_win_q    <= row_win_new;
			if (!first_row_s1) upleft_q <= rd_s1.colour;
			dark_q   <= dark_q + DARK_W'(b_s1);
			run_q    <= run_sum[RUN_W] ? RUN_MAX : run_sum[RUN_W-1:0];
			block_q  <= block_sum[BLOCK_W] ? BLOCK_MAX : block_sum[BLOCK_W-1:0];
			finder_q <= finder_sum[FINDER_W] ? FINDER_MAX : finder_sum[FINDER_W-1:0];
		end
	end

	assign bal_start = (state_q == ST_RUN) && s1_last;

	qmps_balance u_balance (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (bal_start),
		.side   (side),
		.dark   (dark_q),
		.res    (bal_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_RUN;
			out_valid <= 1'b0;
		end else begin
			if (out_valid && !out_stall) out_valid <= 1'b0;
			unique case (state_q)
				ST_RUN: begin
					if (bal_start) state_q <= ST_CALC;
				end
				ST_CALC: begin
					if (bal_res.done) state_q <= ST_OUT;
				end
				ST_OUT: begin
					if (out_free) begin
						out_valid <= 1'b1;
						state_q   <= ST_RUN;
					end
				end
				default: state_q <= ST_RUN;
			endcase
		end
	end

	// hold the result until taken
	always_ff @(posedge clk) begin
		if (state_q == ST_OUT && out_free) begin
			total_score   <= total_sat;
			run_score     <= run_q;
			block_score   <= block_q;
			finder_score  <= finder_q;
			balance_score <= bal_res.balance;
		end
	end

endmodule

### rtl/qmps_balance.sv
// ----------------------------------------------------------------------------
// qmps_balance
// Dark balance penalty: (|2*dark - n*n| * 10 / (n*n)) * 10, worked out by a
// multiply step, a prepare step and a four-step restoring division.
// ----------------------------------------------------------------------------
module qmps_balance import qmps_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [SIDE_W-1:0] side,
	input  logic [DARK_W-1:0] dark,
	output bal_res_t          res
);

	typedef enum logic [3:0] {
		B_IDLE = 4'b0001,
		B_MUL  = 4'b0010,
		B_PREP = 4'b0100,
		B_DIV  = 4'b1000
	} bal_state_t;

	bal_state_t        state_q;
	logic [15:0]       nn_q;
	logic [19:0]       rem_q;
	logic [3:0]        quo_q;
	logic [1:0]        step_q;
	logic [BAL_W-1:0]  bal_q;
	logic              done_q;

	logic [16:0] dark2;
	logic [16:0] nn_ext;
	logic [16:0] diff;
	logic [19:0] diff_x10;
	logic [19:0] trial;
	logic        quo_bit;
	logic [3:0]  quo_next;
	logic [BAL_W-1:0] quo_x10;

	always_comb begin
		dark2    = {dark, 1'b0};
		nn_ext   = {1'b0, nn_q};
		diff     = (dark2 >= nn_ext) ? dark2 - nn_ext : nn_ext - dark2;
		// diff never exceeds n*n, so sixteen bits carry it
		diff_x10 = ({4'b0, diff[15:0]} << 3) + ({4'b0, diff[15:0]} << 1);
		trial    = {4'b0, nn_q} << step_q;
		quo_bit  = rem_q >= trial;
		quo_next = {quo_q[2:0], quo_bit};
		quo_x10  = ({3'b0, quo_next} << 3) + ({3'b0, quo_next} << 1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= B_IDLE;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				B_IDLE: begin
					if (start) state_q <= B_MUL;
				end
				B_MUL:  state_q <= B_PREP;
				B_PREP: state_q <= B_DIV;
				B_DIV: begin
					if (step_q == 2'd0) begin
						done_q  <= 1'b1;
						state_q <= B_IDLE;
					end
				end
				default: state_q <= B_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			B_MUL: nn_q <= 16'(side) * 16'(side);
			B_PREP: begin
				rem_q  <= diff_x10;
				quo_q  <= '0;
				step_q <= 2'd3;
			end
			B_DIV: begin
				if (quo_bit) rem_q <= rem_q - trial;
				quo_q  <= quo_next;
				step_q <= step_q - 2'd1;
				if (step_q == 2'd0) bal_q <= quo_x10;
			end
			default: ;
		endcase
	end

	assign res.done    = done_q;
	assign res.balance = bal_q;

endmodule

### test/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Testbench for the QR mask penalty scorer. Whole symbols are streamed one
// module per item at sizes from zero up to 21 and in several colour styles:
// uniform noise, biased density, flat fills and tiled finder-like rows. The
// symbol size is set over the APB port between symbols. A scoreboard follows
// the scan, works out the four rule scores, and compares each emitted score
// set with the oldest one it expects. Both sides idle and stall at random,
// and the output is held off for a long stretch once so that the input backs up.
// ----------------------------------------------------------------------------
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import qmps_pkg::*;

	localparam int CYCLE_LIMIT  = 1_000_000;
	localparam int DRAIN_CYCLES = 20;
	localparam int HOLD_CYCLES  = 400;
	localparam int ITEM_GOAL    = 180;
	localparam int SYMBOL_GOAL  = 4;

	localparam logic [2:0]  SIZE_ADDR   = {REG_MATRIX_SIZE, 2'b00};
	// 0000 1011101 00000: every cyclic read holds both finder windows
	localparam logic [15:0] FINDER_TILE = 16'b0000_1011_1010_0000;

	typedef enum int {
		STYLE_UNIFORM,
		STYLE_BIASED,
		STYLE_FINDER,
		STYLE_FLAT
	} fill_style_e;

	typedef struct packed {
		logic [TOTAL_W-1:0]  total;
		logic [RUN_W-1:0]    run;
		logic [BLOCK_W-1:0]  block;
		logic [FINDER_W-1:0] finder;
		logic [BAL_W-1:0]    balance;
	} score_t;

	class penalty_scoreboard;
		bit [SIDE_W-1:0] size_reg;
		int unsigned     row, col, row_run, row_win;
		bit              row_colour;
		int unsigned     col_run [256];
		bit              col_colour [256];
		int unsigned     col_win [256];
		bit              above_left [256];
		int unsigned     dark, run_acc, block_acc, finder_acc;
		score_t          expected_scores [$];
		int              errors;

		function new();
			size_reg = 8'd21;
			errors = 0;
			restart();
		endfunction

		function void restart();
			row = 0;
			col = 0;
			row_run = 0;
			row_colour = 1'b0;
			row_win = 0;
			dark = 0;
			run_acc = 0;
			block_acc = 0;
			finder_acc = 0;
		endfunction

		function void set_size(bit [SIDE_W-1:0] value);
			size_reg = value;
			restart();
		endfunction

		function int unsigned sat(int unsigned a, int unsigned b, int unsigned cap);
			return (a + b > cap) ? cap : a + b;
		endfunction

		function void close_run(int unsigned len);
			if (len >= RUN_MIN)
				run_acc = sat(run_acc, len - RUN_BIAS, RUN_MAX);
		endfunction

		function void check_window(int unsigned win);
			if (win == FINDER_LEAD || win == FINDER_TRAIL)
				finder_acc = sat(finder_acc, FINDER_PTS, FINDER_MAX);
		endfunction

		function void note_module(bit b);
			int unsigned n, nn, d2, diff, bal, total;
			bit          above;
			score_t      s;
			n = (size_reg == 0) ? 1 : size_reg;
			if (col >= n || row >= n)
				restart();

			// 2x2 block: left, above and above-left before any update
			if (row > 0) begin
				above = col_colour[col];
				if (col > 0 && b == row_colour && b == above && b == above_left[col - 1])
					block_acc = sat(block_acc, BLOCK_PTS, BLOCK_MAX);
				above_left[col] = above;
			end

			if (col == 0) begin
				row_run = 1;
				row_colour = b;
				row_win = b;
			end else begin
				if (b == row_colour) begin
					if (row_run < RUN_LEN_MAX)
						row_run++;
				end else begin
					close_run(row_run);
					row_run = 1;
					row_colour = b;
				end
				row_win = ((row_win << 1) | b) & 11'h7FF;
			end
			if (col >= WIN_START)
				check_window(row_win);
			if (col == n - 1)
				close_run(row_run);

			if (row == 0) begin
				col_run[col] = 1;
				col_colour[col] = b;
				col_win[col] = b;
			end else begin
				if (b == col_colour[col]) begin
					if (col_run[col] < RUN_LEN_MAX)
						col_run[col]++;
				end else begin
					close_run(col_run[col]);
					col_run[col] = 1;
					col_colour[col] = b;
				end
				col_win[col] = ((col_win[col] << 1) | b) & 11'h7FF;
			end
			if (row >= WIN_START)
				check_window(col_win[col]);
			if (row == n - 1)
				close_run(col_run[col]);

			dark = (dark + b) & 16'hFFFF;

			if (col + 1 < n) begin
				col++;
				return;
			end
			col = 0;
			if (row + 1 < n) begin
				row++;
				return;
			end

			nn = n * n;
			d2 = dark * 2;
			diff = (d2 > nn) ? d2 - nn : nn - d2;
			bal = diff * 10 / nn * 10;
			total = run_acc + block_acc;
			total = sat(total, finder_acc, TOTAL_MAX);
			total = sat(total, bal, TOTAL_MAX);
			s.total = TOTAL_W'(total);
			s.run = RUN_W'(run_acc);
			s.block = BLOCK_W'(block_acc);
			s.finder = FINDER_W'(finder_acc);
			s.balance = BAL_W'(bal);
			expected_scores.push_back(s);
			restart();
		endfunction

		function void compare_field(string name, int unsigned want, int unsigned got);
			if (want != got) begin
				$display("%0t: %s expected %0d actual %0d", $time, name, want, got);
				errors++;
			end
		endfunction

		function void check_score(score_t got);
			score_t want;
			if (expected_scores.size() == 0) begin
				$display("%0t: score with none expected, expected none actual total %0d",
					$time, got.total);
				errors++;
				return;
			end
			want = expected_scores.pop_front();
			compare_field("total_score", want.total, got.total);
			compare_field("run_score", want.run, got.run);
			compare_field("block_score", want.block, got.block);
			compare_field("finder_score", want.finder, got.finder);
			compare_field("balance_score", want.balance, got.balance);
		endfunction
	endclass

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                psel = 1'b0;
	logic                penable = 1'b0;
	logic                pwrite = 1'b0;
	logic [2:0]          paddr = '0;
	logic [31:0]         pwdata = '0;
	logic [31:0]         prdata;
	logic                pready;
	logic                in_valid = 1'b0;
	logic                in_stall;
	logic                module_dark = 1'b0;
	logic                out_valid;
	logic                out_stall = 1'b0;
	logic [TOTAL_W-1:0]  total_score;
	logic [RUN_W-1:0]    run_score;
	logic [BLOCK_W-1:0]  block_score;
	logic [FINDER_W-1:0] finder_score;
	logic [BAL_W-1:0]    balance_score;

	penalty_scoreboard sb = new();

	bit sym [256][256];
	int src_idle_pct = 0;
	int sink_stall_pct = 0;
	int hold_trigger = 0;
	int hold_seen = 0;
	int hold_left = 0;
	int items_sent = 0;
	int cycles = 0;

	qr_mask_penalty_score_top #(
		.MAX_SIZE(256)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.module_dark(module_dark),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.total_score(total_score),
		.run_score(run_score),
		.block_score(block_score),
		.finder_score(finder_score),
		.balance_score(balance_score)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("FAILED: results differ");
			$finish;
		end
	end

	// receiver: random stalls, or a long hold-off when asked for one
	always @(posedge clk) begin
		if (hold_trigger != hold_seen) begin
			hold_seen = hold_trigger;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			out_stall <= 1'b1;
			hold_left--;
		end else begin
			out_stall <= ($urandom_range(0, 99) < sink_stall_pct);
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			sb.check_score(score_t'{total_score, run_score, block_score, finder_score,
				balance_score});
	end

	task automatic send_module(input bit b);
		while ($urandom_range(0, 99) < src_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		module_dark <= b;
		do @(posedge clk); while (in_stall);
		sb.note_module(b);
		items_sent++;
	endtask

	task automatic send_symbol(input int size);
		int n;
		n = (size == 0) ? 1 : size;
		for (int r = 0; r < n; r++)
			for (int c = 0; c < n; c++)
				send_module(sym[r][c]);
	endtask

	// drop valid, wait out every expected score, then let the pipeline settle
	task automatic drain();
		in_valid <= 1'b0;
		while (sb.expected_scores.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_size(input int value);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= SIZE_ADDR;
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		sb.set_size(SIDE_W'(value));
	endtask

	task automatic build_symbol(input int size, input fill_style_e style);
		int n, p, s, ofs, noise;
		bit v;
		n = (size == 0) ? 1 : size;
		p = $urandom_range(0, 100);
		s = $urandom_range(0, 15);
		ofs = $urandom_range(0, 15);
		noise = $urandom_range(0, 8);
		v = 1'($urandom_range(0, 1));
		for (int r = 0; r < n; r++)
			for (int c = 0; c < n; c++)
				case (style)
					STYLE_UNIFORM: sym[r][c] = 1'($urandom_range(0, 1));
					STYLE_BIASED:  sym[r][c] = ($urandom_range(0, 99) < p);
					STYLE_FINDER:  sym[r][c] = FINDER_TILE[15 - ((c + r * s + ofs) % 16)]
						^ ($urandom_range(0, 99) < noise);
					default:       sym[r][c] = v ^ ($urandom_range(0, 99) < noise);
				endcase
	endtask

	task automatic run_phase(input int src, input int sink);
		int size, start, symbols;
		fill_style_e style;
		src_idle_pct = src;
		sink_stall_pct = sink;
		start = items_sent;
		symbols = 0;
		while (items_sent - start < ITEM_GOAL || symbols < SYMBOL_GOAL) begin
			case ($urandom_range(0, 9))
				0, 1:    size = $urandom_range(0, 4);
				8:       size = $urandom_range(11, 14);
				9:       size = $urandom_range(15, 21);
				default: size = $urandom_range(2, 10);
			endcase
			case ($urandom_range(0, 9))
				0, 1, 2: style = STYLE_UNIFORM;
				3, 4:    style = STYLE_BIASED;
				5, 6, 7: style = STYLE_FINDER;
				default: style = STYLE_FLAT;
			endcase
			if (size != sb.size_reg || $urandom_range(0, 2) == 0) begin
				drain();
				write_size(size);
			end
			build_symbol(size, style);
			send_symbol(size);
			symbols++;
		end
		drain();
	endtask

	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		// size left at its reset value
		build_symbol(21, STYLE_UNIFORM);
		send_symbol(21);

		// zero size scans as one module per symbol
		drain();
		write_size(0);
		send_module(1'b1);
		send_module(1'b0);
		drain();
		write_size(1);
		send_module(1'b0);
		send_module(1'b1);
		drain();
		write_size(2);
		repeat (4) send_module(1'b1);
		send_module(1'b1);
		send_module(1'b0);
		send_module(1'b0);
		send_module(1'b1);
		drain();
		write_size(3);
		for (int i = 0; i < 9; i++)
			send_module(i[0]);

		// hold the output off while small symbols keep coming
		drain();
		write_size(2);
		hold_trigger++;
		repeat (40) begin
			build_symbol(2, STYLE_UNIFORM);
			send_symbol(2);
		end
		drain();

		run_phase(0, 0);
		run_phase(59, 0);
		run_phase(0, 59);
		run_phase(33, 33);

		if (sb.errors == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

endmodule
